### src/ksma_pkg.sv
package ksma_pkg;

  localparam int SAMPLE_W = 32;
  localparam int WEIGHT_W = 17;
  localparam int ADDR_W   = 4;
  localparam int DATA_W   = 32;

  // register index, taken from paddr[3:2]
  localparam logic [1:0] REG_MODE  = 2'd0;
  localparam logic [1:0] REG_COEFF = 2'd1;
  localparam logic [1:0] REG_WPOS  = 2'd2;

  localparam logic [16:0] LOG2E_Q16    = 17'd94548;
  localparam logic [15:0] LN2_Q16      = 16'd45426;
  localparam logic [24:0] LN_LIMIT_Q16 = 25'd30180443;
  localparam logic [32:0] ONE_Q32      = 33'h1_0000_0000;
  localparam logic [16:0] WEIGHT_ONE   = 17'h1_0000;
  localparam logic [15:0] COEFF_RESET  = 16'd256;

  // entry i holds 2^(-2^-(i+1)) in Q.32
  localparam logic [31:0] POW_TAB [8] = '{
    32'd3037000500, 32'd3611622603, 32'd3938502376, 32'd4112874773,
    32'd4202934002, 32'd4248701965, 32'd4271771997, 32'd4283353945
  };

  typedef struct packed {
    logic              mode;
    logic [15:0]       ks_coeff;
    logic [15:0]       weight_position;
  } cfg_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] peak;
    logic [WEIGHT_W-1:0]        weight;
    logic                       weight_valid;
    logic                       status;
  } out_item_t;

endpackage

### src/ksma_cfg.sv
module ksma_cfg import ksma_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode            <= 1'b0;
      cfg.ks_coeff        <= COEFF_RESET;
      cfg.weight_position <= '0;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_MODE:  cfg.mode            <= pwdata[0];
        REG_COEFF: cfg.ks_coeff        <= pwdata[15:0];
        REG_WPOS:  cfg.weight_position <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_MODE:  prdata = {31'b0, cfg.mode};
      REG_COEFF: prdata = {16'b0, cfg.ks_coeff};
      REG_WPOS:  prdata = {16'b0, cfg.weight_position};
      default:   prdata = '0;
    endcase
  end

endmodule

### src/ksma_div.sv
module ksma_div import ksma_pkg::*; #(
  parameter int NUM_W = 49,
  parameter int DEN_W = 49
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quot
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] dvs;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DEN_W:0]   shifted;
  logic             fits;

  // restoring step, one quotient bit per cycle
  assign shifted = {rem, quot[NUM_W-1]};
  assign fits    = shifted >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= !start && busy && (cnt == CNT_W'(1));
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= num;
      rem  <= '0;
      dvs  <= den;
      cnt  <= CNT_W'(NUM_W);
    end else if (busy) begin
      rem  <= fits ? DEN_W'(shifted - {1'b0, dvs}) : shifted[DEN_W-1:0];
      quot <= {quot[NUM_W-2:0], fits};
      cnt  <= cnt - CNT_W'(1);
    end
  end

endmodule

### src/ks_soft_max_aggregator_core.sv
// Channel  | Handshake                  | Payload
// ---------+----------------------------+---------------------------------
// input    | in_valid / in_ready        | in_data  : sample, last
// output   | out_valid / out_ready      | out_data : peak, weight, ...
// config   | psel/penable/pwrite/pready | paddr, pwdata, prdata
//
// One shared multiplier under a sequencer; in_ready is high only when idle.
// A sample that is not last scales x and max, runs exp by 8 table steps plus
// a fraction step, then updates the sum; a new max also rescales the sum.
// A last sample in KS mode adds the ln (up to COUNT_WIDTH normalize steps and
// 16 squarings), a divide unless the total is over the limit, and for a seen
// weight position another exp and divide. Plain mode ends after the sum update.
// Reset (rst, synchronous) clears control and run state; no clearing pass.
// A result waits in the output register; a stall there holds the next result
// in S_OUT, and in_ready stays low until that result can load.
module ks_soft_max_aggregator_core import ksma_pkg::*; #(
  parameter int FRACTION_BITS = 16,
  parameter int COUNT_WIDTH   = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  localparam int FB    = FRACTION_BITS;
  localparam int CW    = COUNT_WIDTH;
  localparam int SUM_W = CW + 33;
  localparam int Y_W   = SAMPLE_W + 9;             // x*c/256, signed
  localparam int D_W   = Y_W;                      // exp argument, unsigned
  localparam int T_W   = D_W + 1;                  // d*log2(e)
  localparam int MA    = 34;
  localparam int MB    = 34;
  localparam int PW    = MA + MB;
  localparam int P_W   = $clog2(SUM_W);
  localparam int LN_W  = P_W + 16;
  localparam int UP_W  = (FB > 16) ? FB - 16 : 0;
  localparam int QL_W  = LN_W + UP_W;
  localparam int PN_W  = QL_W + 8;
  localparam int DN_W  = (PN_W > 49) ? PN_W : 49;
  localparam int PK_W  = DN_W + 2;
  localparam int TOT_W = ((Y_W > QL_W) ? Y_W : QL_W) + 2;
  localparam int LIM_W = (D_W > FB + 8) ? D_W : FB + 8;
  localparam int ST_W  = 28;

  localparam logic signed [SAMPLE_W-1:0] SMIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
  localparam logic signed [SAMPLE_W-1:0] SMAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic [SUM_W-1:0] SUM_ONE = SUM_W'(ONE_Q32);
  localparam logic [SUM_W-1:0] SUM_SAT = {SUM_W{1'b1}};
  localparam logic [LIM_W-1:0] EXP_CUT = LIM_W'(64) << FB;
  localparam logic signed [TOT_W-1:0] LN_LIMIT =
    TOT_W'(({LN_LIMIT_Q16, {FB{1'b0}}}) >> 16);

  typedef enum logic [ST_W-1:0] {
    S_IDLE  = ST_W'(1) << 0,
    S_YX    = ST_W'(1) << 1,
    S_YM    = ST_W'(1) << 2,
    S_DIFF  = ST_W'(1) << 3,
    S_ET    = ST_W'(1) << 4,
    S_EK    = ST_W'(1) << 5,
    S_EB    = ST_W'(1) << 6,
    S_ER1   = ST_W'(1) << 7,
    S_ER2   = ST_W'(1) << 8,
    S_ES    = ST_W'(1) << 9,
    S_UPD   = ST_W'(1) << 10,
    S_MLO   = ST_W'(1) << 11,
    S_MHI   = ST_W'(1) << 12,
    S_ACC   = ST_W'(1) << 13,
    S_FIN   = ST_W'(1) << 14,
    S_YMX   = ST_W'(1) << 15,
    S_LN0   = ST_W'(1) << 16,
    S_NORM  = ST_W'(1) << 17,
    S_SQ    = ST_W'(1) << 18,
    S_LNC   = ST_W'(1) << 19,
    S_TOT   = ST_W'(1) << 20,
    S_PWAIT = ST_W'(1) << 21,
    S_WGT   = ST_W'(1) << 22,
    S_YC    = ST_W'(1) << 23,
    S_WD    = ST_W'(1) << 24,
    S_WDIV  = ST_W'(1) << 25,
    S_WWAIT = ST_W'(1) << 26,
    S_OUT   = ST_W'(1) << 27
  } state_t;

  state_t state;
  cfg_t   cfg;

  // run state
  logic signed [SAMPLE_W-1:0] run_max;
  logic [SUM_W-1:0]           ssum;
  logic signed [SAMPLE_W-1:0] chosen;
  logic                       chosen_seen;
  logic [CW-1:0]              pos_cnt;

  // per-item working registers
  logic signed [SAMPLE_W-1:0] x_reg;
  logic                       last_reg;
  logic [15:0]                c_reg;
  logic signed [Y_W-1:0]      y_reg;
  logic signed [Y_W-1:0]      ym_reg;
  logic                       gt_reg;
  logic [D_W-1:0]             d_reg;
  logic [T_W-1:0]             t_reg;
  logic                       ez_reg;
  logic [5:0]                 k_reg;
  logic [15:0]                f16_reg;
  logic [32:0]                m_reg;
  logic [2:0]                 bit_idx;
  logic [23:0]                r_tmp;
  logic [32:0]                e_reg;
  logic                       ret_w;
  logic [31:0]                acc_lo;
  logic [SUM_W:0]             acc_hi;
  logic [SUM_W-1:0]           nrm;
  logic [P_W-1:0]             p_reg;
  logic [30:0]                mm;
  logic [3:0]                 sq_idx;
  logic [15:0]                frac;
  logic [LN_W-1:0]            ln_reg;

  // result registers
  logic signed [SAMPLE_W-1:0] peak_r;
  logic [WEIGHT_W-1:0]        weight_r;
  logic                       wvalid_r;
  logic                       status_r;

  // shared multiplier
  logic signed [MA-1:0] mul_a;
  logic signed [MB-1:0] mul_b;
  logic signed [PW-1:0] prod;

  // divider
  logic            div_start;
  logic [DN_W-1:0] div_num;
  logic [SUM_W-1:0] div_den;
  logic            div_done;
  logic [DN_W-1:0] div_quot;

  // combinational helpers
  logic                    accept;
  logic                    out_load;
  logic [T_W-1:0]          k_wide;
  logic [FB-1:0]           f_frac;
  logic [SUM_W:0]          add_sum;
  logic [SUM_W+1:0]        acc_sum;
  logic [31:0]             sq;
  logic [QL_W-1:0]         ln_frac;
  logic signed [TOT_W-1:0] total;
  logic signed [PK_W-1:0]  peak_sum;

  ksma_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ksma_div #(
    .NUM_W (DN_W),
    .DEN_W (SUM_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid & in_ready;
  assign out_load = (state == S_OUT) && (!out_valid || out_ready);

  assign prod = mul_a * mul_b;

  // operand select for the one multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_YX:  begin mul_a = MA'(x_reg);         mul_b = MB'(c_reg);                 end
      S_YM,
      S_YMX: begin mul_a = MA'(run_max);       mul_b = MB'(c_reg);                 end
      S_YC:  begin mul_a = MA'(chosen);        mul_b = MB'(c_reg);                 end
      // d at or above 64.0 is flagged zero, so its low bits are enough here
      S_ET:  begin mul_a = MA'(d_reg[FB+6:0]); mul_b = MB'(LOG2E_Q16);             end
      S_EB:  begin mul_a = MA'(m_reg);         mul_b = MB'(POW_TAB[bit_idx]);      end
      S_ER1: begin mul_a = MA'(f16_reg[7:0]);  mul_b = MB'(LN2_Q16);               end
      S_ER2: begin mul_a = MA'(m_reg);         mul_b = MB'(ONE_Q32 - 33'(r_tmp));  end
      S_MLO: begin mul_a = MA'(ssum[31:0]);    mul_b = MB'(e_reg);                 end
      S_MHI: begin mul_a = MA'(ssum[SUM_W-1:32]); mul_b = MB'(e_reg);             end
      S_SQ:  begin mul_a = MA'(mm);            mul_b = MB'(mm);                    end
      S_LNC: begin
        mul_a = MA'({P_W'(p_reg - P_W'(32)), frac});
        mul_b = MB'(LN2_Q16);
      end
      default: ;
    endcase
  end

  always_comb begin
    k_wide   = t_reg >> FB;
    f_frac   = t_reg[FB-1:0];
    add_sum  = (SUM_W+1)'(ssum) + (SUM_W+1)'(e_reg);
    acc_sum  = (SUM_W+2)'(acc_hi) + (SUM_W+2)'(acc_lo) + (SUM_W+2)'(ONE_Q32);
    sq       = prod[61:30];
    ln_frac  = QL_W'({ln_reg, {FB{1'b0}}} >> 16);
    total    = TOT_W'(ym_reg) + $signed(TOT_W'(ln_frac));
    peak_sum = PK_W'(run_max) + $signed(PK_W'(div_quot));
  end

  // divider operands: peak offset ln*256/c, or weight e*2^16/S
  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    case (state)
      S_TOT: begin
        div_start = !(total > LN_LIMIT);
        div_num   = DN_W'({ln_reg, 8'b0, {FB{1'b0}}} >> 16);
        div_den   = SUM_W'(c_reg);
      end
      S_WDIV: begin
        div_start = 1'b1;
        div_num   = DN_W'({e_reg, 16'b0});
        div_den   = ssum;
      end
      default: ;
    endcase
  end

  // control and run state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      out_valid   <= 1'b0;
      run_max     <= SMIN;
      ssum        <= '0;
      chosen_seen <= 1'b0;
      pos_cnt     <= '0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (!chosen_seen && pos_cnt == CW'(cfg.weight_position)) begin
              chosen_seen <= 1'b1;
            end
            if (pos_cnt != {CW{1'b1}}) pos_cnt <= pos_cnt + CW'(1);
            state <= S_YX;
          end
        end
        S_YX:   state <= S_YM;
        S_YM:   state <= S_DIFF;
        S_DIFF: state <= S_ET;
        S_ET:   state <= S_EK;
        S_EK:   state <= S_EB;
        S_EB:   if (bit_idx == 3'd7) state <= S_ER1;
        S_ER1:  state <= (f16_reg[7:0] != 8'd0) ? S_ER2 : S_ES;
        S_ER2:  state <= S_ES;
        S_ES:   state <= ret_w ? S_WDIV : S_UPD;
        S_UPD: begin
          if (gt_reg) begin
            state <= S_MLO;
          end else begin
            ssum  <= add_sum[SUM_W] ? SUM_SAT : add_sum[SUM_W-1:0];
            state <= last_reg ? S_FIN : S_IDLE;
          end
        end
        S_MLO: state <= S_MHI;
        S_MHI: state <= S_ACC;
        S_ACC: begin
          ssum    <= (acc_sum > (SUM_W+2)'(SUM_SAT)) ? SUM_SAT : acc_sum[SUM_W-1:0];
          run_max <= x_reg;
          state   <= last_reg ? S_FIN : S_IDLE;
        end
        S_FIN:   state <= cfg.mode ? S_OUT : S_YMX;
        S_YMX:   state <= S_LN0;
        S_LN0:   state <= (ssum < SUM_ONE) ? S_TOT : S_NORM;
        S_NORM:  if (nrm[SUM_W-1]) state <= S_SQ;
        S_SQ:    if (sq_idx == 4'd15) state <= S_LNC;
        S_LNC:   state <= S_TOT;
        S_TOT:   state <= (total > LN_LIMIT) ? S_WGT : S_PWAIT;
        S_PWAIT: if (div_done) state <= S_WGT;
        S_WGT:   state <= chosen_seen ? S_YC : S_OUT;
        S_YC:    state <= S_WD;
        S_WD:    state <= S_ET;
        S_WDIV:  state <= S_WWAIT;
        S_WWAIT: if (div_done) state <= S_OUT;
        S_OUT: begin
          if (out_load) begin
            run_max     <= SMIN;
            ssum        <= '0;
            chosen_seen <= 1'b0;
            pos_cnt     <= '0;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          x_reg    <= in_data.sample;
          last_reg <= in_data.last;
          c_reg    <= (cfg.ks_coeff != 16'd0) ? cfg.ks_coeff : 16'd1;
          if (!chosen_seen && pos_cnt == CW'(cfg.weight_position)) begin
            chosen <= in_data.sample;
          end
        end
      end
      S_YX:  y_reg  <= Y_W'(prod >>> 8);
      S_YM:  ym_reg <= Y_W'(prod >>> 8);
      S_YMX: ym_reg <= Y_W'(prod >>> 8);
      S_YC:  y_reg  <= Y_W'(prod >>> 8);
      S_DIFF: begin
        gt_reg <= x_reg > run_max;
        d_reg  <= (x_reg > run_max) ? D_W'(y_reg - ym_reg) : D_W'(ym_reg - y_reg);
        ret_w  <= 1'b0;
      end
      S_WD: begin
        d_reg <= D_W'(ym_reg - y_reg);
        ret_w <= 1'b1;
      end
      // exp(-d): 2^-(t) split into integer shift k and table fraction
      S_ET: begin
        t_reg  <= prod[T_W+15:16];
        ez_reg <= LIM_W'(d_reg) >= EXP_CUT;
      end
      S_EK: begin
        if (k_wide > T_W'(32)) ez_reg <= 1'b1;
        k_reg   <= k_wide[5:0];
        f16_reg <= 16'({f_frac, 16'b0} >> FB);
        m_reg   <= ONE_Q32;
        bit_idx <= 3'd0;
      end
      S_EB: begin
        if (f16_reg[{1'b1, ~bit_idx}]) m_reg <= prod[64:32];
        bit_idx <= bit_idx + 3'd1;
      end
      S_ER1: r_tmp <= prod[23:0];
      S_ER2: m_reg <= prod[64:32];
      S_ES:  e_reg <= ez_reg ? 33'd0 : (m_reg >> k_reg);
      S_MLO: acc_lo <= prod[63:32];
      S_MHI: acc_hi <= prod[SUM_W:0];
      S_FIN: begin
        peak_r   <= run_max;
        weight_r <= '0;
        wvalid_r <= 1'b0;
        status_r <= 1'b0;
      end
      S_LN0: begin
        ln_reg <= '0;
        nrm    <= ssum;
        p_reg  <= P_W'(SUM_W - 1);
      end
      S_NORM: begin
        if (nrm[SUM_W-1]) begin
          mm     <= nrm[SUM_W-1 -: 31];
          sq_idx <= 4'd0;
          frac   <= '0;
        end else begin
          nrm   <= nrm << 1;
          p_reg <= p_reg - P_W'(1);
        end
      end
      S_SQ: begin
        if (sq[31]) begin
          frac[~sq_idx] <= 1'b1;
          mm            <= sq[31:1];
        end else begin
          mm <= sq[30:0];
        end
        sq_idx <= sq_idx + 4'd1;
      end
      S_LNC: ln_reg <= prod[LN_W+15:16];
      S_TOT: begin
        status_r <= total > LN_LIMIT;
        peak_r   <= SMAX;
      end
      S_PWAIT: begin
        if (div_done) begin
          peak_r <= (peak_sum > PK_W'(SMAX)) ? SMAX : peak_sum[SAMPLE_W-1:0];
        end
      end
      S_WGT: begin
        weight_r <= '0;
        wvalid_r <= 1'b0;
      end
      S_WWAIT: begin
        if (div_done) begin
          wvalid_r <= 1'b1;
          if (ssum == '0) weight_r <= '0;
          else if (div_quot > DN_W'(WEIGHT_ONE)) weight_r <= WEIGHT_ONE;
          else weight_r <= div_quot[WEIGHT_W-1:0];
        end
      end
      S_OUT: begin
        if (out_load) begin
          out_data.peak         <= peak_r;
          out_data.weight       <= weight_r;
          out_data.weight_valid <= wvalid_r;
          out_data.status       <= status_r;
        end
      end
      default: ;
    endcase
  end

`ifndef ASSERT_OFF
  a_out_only_last: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT) |-> last_reg)
    else $error("result stage reached for a sample without last");

  a_div_done_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_PWAIT || state == S_WWAIT))
    else $error("divider finished outside a wait state");

  a_exp_shift: assert property (@(posedge clk) disable iff (rst)
    (state == S_ES && !ez_reg) |-> (k_reg <= 6'd32))
    else $error("exp shift out of range");

  a_sum_floor: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN) |-> (ssum >= SUM_ONE))
    else $error("scaled sum below one at end of run");
`endif

endmodule
